FILE: design/nearest_object_association_table_defines.svh
// ----------------------------------------------------------------------------
// nearest_object_association_table_defines
// assertion macros shared by the checker of the association table
// ----------------------------------------------------------------------------
`ifndef NEAREST_OBJECT_ASSOCIATION_TABLE_DEFINES_SVH
`define NEAREST_OBJECT_ASSOCIATION_TABLE_DEFINES_SVH

// property that must hold in the same cycle as its trigger
`define NOAT_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// property that must hold in the cycle after its trigger
`define NOAT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/noat_pkg.sv
// ----------------------------------------------------------------------------
// noat_pkg
// types, constants and command/status bundles of the association table
// ----------------------------------------------------------------------------
package noat_pkg;

    // default sizing
    localparam int CAPACITY_DEF  = 64;
    localparam int FRAC_BITS_DEF = 8;

    // field widths
    localparam int COORD_W = 32;
    localparam int LABEL_W = 8;
    localparam int SIGHT_W = 16;
    localparam int ID_W    = 10;
    localparam int DELTA_W = 16;
    localparam int APB_DW  = 32;
    localparam int APB_AW  = 3;

    // constants
    localparam logic [SIGHT_W-1:0]        SIGHT_MAX   = 16'hFFFF;
    localparam logic [DELTA_W-1:0]        DELTA_RESET = 16'd1;
    localparam logic signed [COORD_W-1:0] COORD_MAX   = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] COORD_MIN   = 32'sh8000_0000;

    // register index, taken from the word address bit
    localparam logic REG_IDENTITY_DELTA = 1'b0;

    // one table entry
    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [LABEL_W-1:0]        label;
        logic [SIGHT_W-1:0]        sightings;
    } t_entry;

    // which result word the datapath forms
    typedef enum logic [1:0] {
        RES_MATCH,
        RES_APPEND,
        RES_FULL,
        RES_ZERO
    } t_res_sel;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_MERGE,
        ST_APPEND,
        ST_FULL,
        ST_SHIFT_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic     start;
        logic     rd_en;
        logic     wr_merge;
        logic     wr_append;
        logic     load_out;
        t_res_sel res_sel;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic pipe_busy;
        logic found;
        logic is_shift;
        logic out_free;
    } t_status;

endpackage

FILE: design/nearest_object_association_table.sv
// One item at a time: a new item is taken only after the result word of the last one is loaded.
// The sweep reads one entry per cycle into the three-stage compare pipeline.
// Reset (synchronous, active low) empties the table and sets identity_delta to 1.
// ----------------------------------------------------------------------------
// nearest_object_association_table
// nearest-neighbor association of detections with a table of tracked objects
// ----------------------------------------------------------------------------
module nearest_object_association_table #(
    parameter int CAPACITY  = noat_pkg::CAPACITY_DEF,
    parameter int FRAC_BITS = noat_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_kind,
    input  logic signed [noat_pkg::COORD_W-1:0] i_pos_x,
    input  logic signed [noat_pkg::COORD_W-1:0] i_pos_y,
    input  logic [noat_pkg::LABEL_W-1:0]        i_class_label,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_matched,
    output logic                                o_table_full,
    output logic [noat_pkg::ID_W-1:0]           o_object_id,
    output logic [noat_pkg::SIGHT_W-1:0]        o_sighting_count,
    output logic signed [noat_pkg::COORD_W-1:0] o_out_x,
    output logic signed [noat_pkg::COORD_W-1:0] o_out_y,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [noat_pkg::APB_AW-1:0]         paddr,
    input  logic [noat_pkg::APB_DW-1:0]         pwdata,
    output logic [noat_pkg::APB_DW-1:0]         prdata,
    output logic                                pready
);

    localparam int IDX_W = $clog2(CAPACITY);

    logic [noat_pkg::DELTA_W-1:0] r_delta;
    noat_pkg::t_cmd               w_cmd;
    noat_pkg::t_status            w_status;
    logic [IDX_W-1:0]             w_addr;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delta <= noat_pkg::DELTA_RESET;
        end else if (psel && penable && pwrite && pready &&
                     (paddr[2] == noat_pkg::REG_IDENTITY_DELTA)) begin
            r_delta <= pwdata[noat_pkg::DELTA_W-1:0];
        end
    end

    // register read back
    assign pready = 1'b1;
    assign prdata = (paddr[2] == noat_pkg::REG_IDENTITY_DELTA)
                    ? noat_pkg::APB_DW'(r_delta) : '0;

    noat_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd),
        .o_addr     (w_addr)
    );

    noat_dp #(
        .CAPACITY  (CAPACITY),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_status         (w_status),
        .i_addr           (w_addr),
        .i_kind           (i_kind),
        .i_pos_x          (i_pos_x),
        .i_pos_y          (i_pos_y),
        .i_class_label    (i_class_label),
        .i_delta          (r_delta),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_matched        (o_matched),
        .o_table_full     (o_table_full),
        .o_object_id      (o_object_id),
        .o_sighting_count (o_sighting_count),
        .o_out_x          (o_out_x),
        .o_out_y          (o_out_y)
    );

endmodule

FILE: design/noat_ctrl.sv
// ----------------------------------------------------------------------------
// noat_ctrl
// sequencer: accepts an item, sweeps the entries, then picks the write-back
// ----------------------------------------------------------------------------
module noat_ctrl #(
    parameter int  CAPACITY = noat_pkg::CAPACITY_DEF,
    localparam int IDX_W    = $clog2(CAPACITY),
    localparam int CNT_W    = $clog2(CAPACITY + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  noat_pkg::t_status i_status,
    output noat_pkg::t_cmd    o_cmd,
    output logic [IDX_W-1:0]  o_addr
);

    noat_pkg::t_state r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [CNT_W-1:0] r_count, n_count;

    // state, sweep index and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= noat_pkg::ST_IDLE;
            r_idx   <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_count <= n_count;
        end
    end

    // next state and commands
    always_comb begin
        n_state       = r_state;
        n_idx         = r_idx;
        n_count       = r_count;
        o_cmd         = '0;
        o_cmd.res_sel = noat_pkg::RES_ZERO;
        o_addr        = r_idx;
        o_in_stall    = 1'b1;
        unique case (r_state)
            noat_pkg::ST_IDLE: begin
                // no word taken while reset is held
                o_in_stall = !i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    o_cmd.start = 1'b1;
                    n_idx       = '0;
                    n_state     = (r_count == '0) ? noat_pkg::ST_DRAIN : noat_pkg::ST_SCAN;
                end
            end
            noat_pkg::ST_SCAN: begin
                // one entry read per cycle
                o_cmd.rd_en = 1'b1;
                n_idx       = r_idx + 1'b1;
                if (CNT_W'(r_idx) + CNT_W'(1) == r_count) begin
                    n_state = noat_pkg::ST_DRAIN;
                end
            end
            noat_pkg::ST_DRAIN: begin
                // wait for the compare pipeline to empty
                if (!i_status.pipe_busy) begin
                    priority if (i_status.is_shift) begin
                        n_state = noat_pkg::ST_SHIFT_DONE;
                    end else if (i_status.found) begin
                        n_state = noat_pkg::ST_MERGE;
                    end else if (r_count == CNT_W'(CAPACITY)) begin
                        n_state = noat_pkg::ST_FULL;
                    end else begin
                        n_state = noat_pkg::ST_APPEND;
                    end
                end
            end
            noat_pkg::ST_MERGE: begin
                o_cmd.res_sel = noat_pkg::RES_MATCH;
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    o_cmd.wr_merge = 1'b1;
                    n_state        = noat_pkg::ST_IDLE;
                end
            end
            noat_pkg::ST_APPEND: begin
                o_cmd.res_sel = noat_pkg::RES_APPEND;
                o_addr        = r_count[IDX_W-1:0];
                if (i_status.out_free) begin
                    o_cmd.load_out  = 1'b1;
                    o_cmd.wr_append = 1'b1;
                    n_count         = r_count + 1'b1;
                    n_state         = noat_pkg::ST_IDLE;
                end
            end
            noat_pkg::ST_FULL: begin
                o_cmd.res_sel = noat_pkg::RES_FULL;
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = noat_pkg::ST_IDLE;
                end
            end
            noat_pkg::ST_SHIFT_DONE: begin
                o_cmd.res_sel = noat_pkg::RES_ZERO;
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = noat_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = noat_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

FILE: design/noat_dp.sv
// ----------------------------------------------------------------------------
// noat_dp
// entry memory, shift write-back, compare pipeline, best pick, result word
// ----------------------------------------------------------------------------
module noat_dp #(
    parameter int  CAPACITY  = noat_pkg::CAPACITY_DEF,
    parameter int  FRAC_BITS = noat_pkg::FRAC_BITS_DEF,
    localparam int IDX_W     = $clog2(CAPACITY),
    localparam int UNITS_W   = 34 - FRAC_BITS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  noat_pkg::t_cmd                        i_cmd,
    output noat_pkg::t_status                     o_status,
    input  logic [IDX_W-1:0]                      i_addr,
    input  logic                                  i_kind,
    input  logic signed [noat_pkg::COORD_W-1:0]   i_pos_x,
    input  logic signed [noat_pkg::COORD_W-1:0]   i_pos_y,
    input  logic [noat_pkg::LABEL_W-1:0]          i_class_label,
    input  logic [noat_pkg::DELTA_W-1:0]          i_delta,
    input  logic                                  i_out_stall,
    output logic                                  o_out_valid,
    output logic                                  o_matched,
    output logic                                  o_table_full,
    output logic [noat_pkg::ID_W-1:0]             o_object_id,
    output logic [noat_pkg::SIGHT_W-1:0]          o_sighting_count,
    output logic signed [noat_pkg::COORD_W-1:0]   o_out_x,
    output logic signed [noat_pkg::COORD_W-1:0]   o_out_y
);

    // saturate a 33-bit sum to the 32-bit signed range
    function automatic logic signed [noat_pkg::COORD_W-1:0] sat33(input logic [32:0] s);
        logic signed [noat_pkg::COORD_W-1:0] r;
        if (s[32] != s[31]) begin
            r = s[32] ? noat_pkg::COORD_MIN : noat_pkg::COORD_MAX;
        end else begin
            r = s[31:0];
        end
        return r;
    endfunction

    noat_pkg::t_entry r_mem [CAPACITY];

    // latched item
    logic                                r_kind;
    logic signed [noat_pkg::COORD_W-1:0] r_px, r_py;
    logic [noat_pkg::LABEL_W-1:0]        r_lab;

    // stage 1: read data
    noat_pkg::t_entry r_rd;
    logic             r_v1;
    logic [IDX_W-1:0] r_i1;

    // stage 2: absolute differences
    logic [32:0]      r_ax, r_ay;
    logic             r_lok;
    noat_pkg::t_entry r_e2;
    logic             r_v2;
    logic [IDX_W-1:0] r_i2;

    // stage 3: window test and distance
    logic             r_win;
    logic [33:0]      r_dist;
    noat_pkg::t_entry r_e3;
    logic             r_v3;
    logic [IDX_W-1:0] r_i3;

    // best candidate
    logic               r_found;
    logic [IDX_W-1:0]   r_best_idx;
    logic [UNITS_W-1:0] r_best_units;
    noat_pkg::t_entry   r_best;

    // result word
    logic                                r_out_valid;
    logic                                r_out_matched;
    logic                                r_out_full;
    logic [noat_pkg::ID_W-1:0]           r_out_id;
    logic [noat_pkg::SIGHT_W-1:0]        r_out_cnt;
    logic signed [noat_pkg::COORD_W-1:0] r_out_x, r_out_y;

    logic [32:0]                         w_win;
    logic [32:0]                         w_sx, w_sy;
    logic [32:0]                         w_dxa, w_dxb, w_dya, w_dyb;
    logic [UNITS_W-1:0]                  w_units;
    logic                                w_take;
    logic [32:0]                         w_mx, w_my;
    logic [noat_pkg::SIGHT_W-1:0]        w_cnt_new;
    logic                                w_wr_en;
    logic [IDX_W-1:0]                    w_wr_addr;
    noat_pkg::t_entry                    w_wr_data;
    logic                                w_res_matched;
    logic                                w_res_full;
    logic [noat_pkg::ID_W-1:0]           w_res_id;
    logic [noat_pkg::SIGHT_W-1:0]        w_res_cnt;
    logic signed [noat_pkg::COORD_W-1:0] w_res_x, w_res_y;

    // window half-width in fixed point
    assign w_win = 33'(i_delta) << FRAC_BITS;

    // shift sums
    assign w_sx = {r_rd.x[31], r_rd.x} + {r_px[31], r_px};
    assign w_sy = {r_rd.y[31], r_rd.y} + {r_py[31], r_py};

    // signed differences both ways, the non-negative one is the magnitude
    assign w_dxa = {r_rd.x[31], r_rd.x} - {r_px[31], r_px};
    assign w_dxb = {r_px[31], r_px} - {r_rd.x[31], r_rd.x};
    assign w_dya = {r_rd.y[31], r_rd.y} - {r_py[31], r_py};
    assign w_dyb = {r_py[31], r_py} - {r_rd.y[31], r_rd.y};

    // whole-unit distance and best update
    assign w_units = r_dist[33:FRAC_BITS];
    assign w_take  = r_v3 && r_win && (!r_found || (w_units < r_best_units));

    // merge: floor average and saturating count
    assign w_mx      = {r_best.x[31], r_best.x} + {r_px[31], r_px};
    assign w_my      = {r_best.y[31], r_best.y} + {r_py[31], r_py};
    assign w_cnt_new = (r_best.sightings == noat_pkg::SIGHT_MAX)
                       ? r_best.sightings : r_best.sightings + 1'b1;

    // single write port
    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = r_i1;
        w_wr_data = r_rd;
        priority if (r_v1 && r_kind) begin
            w_wr_en             = 1'b1;
            w_wr_data.x         = sat33(w_sx);
            w_wr_data.y         = sat33(w_sy);
        end else if (i_cmd.wr_merge) begin
            w_wr_en             = 1'b1;
            w_wr_addr           = r_best_idx;
            w_wr_data.x         = w_mx[32:1];
            w_wr_data.y         = w_my[32:1];
            w_wr_data.label     = r_best.label;
            w_wr_data.sightings = w_cnt_new;
        end else if (i_cmd.wr_append) begin
            w_wr_en             = 1'b1;
            w_wr_addr           = i_addr;
            w_wr_data.x         = r_px;
            w_wr_data.y         = r_py;
            w_wr_data.label     = r_lab;
            w_wr_data.sightings = '0;
        end
    end

    // entry memory
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd <= r_mem[i_addr];
        end
    end

    // item latch and pipeline payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_kind <= i_kind;
            r_px   <= i_pos_x;
            r_py   <= i_pos_y;
            r_lab  <= i_class_label;
        end
        r_i1   <= i_addr;
        r_ax   <= w_dxa[32] ? w_dxb : w_dxa;
        r_ay   <= w_dya[32] ? w_dyb : w_dya;
        r_lok  <= (r_rd.label == r_lab);
        r_e2   <= r_rd;
        r_i2   <= r_i1;
        r_win  <= r_lok && (r_ax < w_win) && (r_ay < w_win);
        r_dist <= {1'b0, r_ax} + {1'b0, r_ay};
        r_e3   <= r_e2;
        r_i3   <= r_i2;
        if (w_take) begin
            r_best_idx   <= r_i3;
            r_best_units <= w_units;
            r_best       <= r_e3;
        end
    end

    // pipeline valids and found flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_found <= 1'b0;
        end else begin
            r_v1 <= i_cmd.rd_en;
            r_v2 <= r_v1 && !r_kind;
            r_v3 <= r_v2;
            if (i_cmd.start) begin
                r_found <= 1'b0;
            end else if (w_take) begin
                r_found <= 1'b1;
            end
        end
    end

    // result word select
    always_comb begin
        w_res_matched = 1'b0;
        w_res_full    = 1'b0;
        w_res_id      = '0;
        w_res_cnt     = '0;
        w_res_x       = '0;
        w_res_y       = '0;
        unique case (i_cmd.res_sel)
            noat_pkg::RES_MATCH: begin
                w_res_matched = 1'b1;
                w_res_id      = noat_pkg::ID_W'(r_best_idx);
                w_res_cnt     = w_cnt_new;
                w_res_x       = w_mx[32:1];
                w_res_y       = w_my[32:1];
            end
            noat_pkg::RES_APPEND: begin
                w_res_id = noat_pkg::ID_W'(i_addr);
                w_res_x  = r_px;
                w_res_y  = r_py;
            end
            noat_pkg::RES_FULL: begin
                w_res_full = 1'b1;
            end
            noat_pkg::RES_ZERO: begin
                w_res_full = 1'b0;
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_matched <= w_res_matched;
            r_out_full    <= w_res_full;
            r_out_id      <= w_res_id;
            r_out_cnt     <= w_res_cnt;
            r_out_x       <= w_res_x;
            r_out_y       <= w_res_y;
        end
    end

    // status to the controller
    assign o_status.pipe_busy = r_v1 | r_v2 | r_v3;
    assign o_status.found     = r_found;
    assign o_status.is_shift  = r_kind;
    assign o_status.out_free  = !r_out_valid || !i_out_stall;

    assign o_out_valid      = r_out_valid;
    assign o_matched        = r_out_matched;
    assign o_table_full     = r_out_full;
    assign o_object_id      = r_out_id;
    assign o_sighting_count = r_out_cnt;
    assign o_out_x          = r_out_x;
    assign o_out_y          = r_out_y;

endmodule

FILE: design/noat_chk.sv
// ----------------------------------------------------------------------------
// noat_chk
// port-level checks of the association table, bound to the top level
// ----------------------------------------------------------------------------
`include "nearest_object_association_table_defines.svh"

module noat_chk (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                o_in_stall,
    input logic                                o_out_valid,
    input logic                                i_out_stall,
    input logic                                o_matched,
    input logic                                o_table_full,
    input logic [noat_pkg::ID_W-1:0]           o_object_id,
    input logic [noat_pkg::SIGHT_W-1:0]        o_sighting_count,
    input logic signed [noat_pkg::COORD_W-1:0] o_out_x,
    input logic signed [noat_pkg::COORD_W-1:0] o_out_y
);

    // a stalled result word stays
    `NOAT_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid, "result word dropped while stalled")

    // a stalled result word keeps its payload
    `NOAT_ASSERT_NEXT(a_out_stable, o_out_valid && i_out_stall, $stable(o_object_id) && $stable(o_sighting_count) && $stable(o_out_x) && $stable(o_out_y) && $stable(o_matched) && $stable(o_table_full), "stalled result word changed")

    // one item at a time: the block stalls right after an accept
    `NOAT_ASSERT_NEXT(a_one_item, i_in_valid && !o_in_stall, o_in_stall, "second word taken while busy")

    // a merge and a drop never go together
    `NOAT_ASSERT_SAME(a_excl, o_out_valid, !(o_matched && o_table_full), "matched and table_full both set")

    // a drop or a fresh entry reports no sightings
    `NOAT_ASSERT_SAME(a_zero_cnt, o_out_valid && !o_matched, o_sighting_count == '0, "unmatched word with nonzero count")

endmodule

bind nearest_object_association_table noat_chk u_noat_chk (.*);

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// checks the association table against its own table predictor: observe and
// shift words with random idling on both channels, window set over apb
// ----------------------------------------------------------------------------
module testbench;

    localparam int CAP        = noat_pkg::CAPACITY_DEF;
    localparam int FRAC       = noat_pkg::FRAC_BITS_DEF;
    localparam int WATCHDOG   = 2000;
    localparam int DRAIN_WAIT = 80;
    localparam int IDLE_GUARD = 8;

    // word kinds
    localparam logic KIND_OBSERVE = 1'b0;
    localparam logic KIND_SHIFT   = 1'b1;

    // register address of the association window
    localparam logic [noat_pkg::APB_AW-1:0] ADDR_IDENTITY_DELTA =
        {noat_pkg::REG_IDENTITY_DELTA, 2'b00};

    // one result word
    typedef struct packed {
        logic                                matched;
        logic                                table_full;
        logic [noat_pkg::ID_W-1:0]           object_id;
        logic [noat_pkg::SIGHT_W-1:0]        sightings;
        logic signed [noat_pkg::COORD_W-1:0] x;
        logic signed [noat_pkg::COORD_W-1:0] y;
    } t_assoc_word;

    // saturate a wide sum to the coordinate range
    function automatic logic signed [noat_pkg::COORD_W-1:0] clamp_coord(input longint v);
        if (v > 64'sd2147483647) return noat_pkg::COORD_MAX;
        if (v < -64'sd2147483648) return noat_pkg::COORD_MIN;
        return v[noat_pkg::COORD_W-1:0];
    endfunction

    // ------------------------------------------------------------------------
    // track table predictor and result checker
    // ------------------------------------------------------------------------
    class track_scoreboard;
        logic signed [noat_pkg::COORD_W-1:0] trk_x [CAP];
        logic signed [noat_pkg::COORD_W-1:0] trk_y [CAP];
        logic [noat_pkg::LABEL_W-1:0]        trk_label [CAP];
        logic [noat_pkg::SIGHT_W-1:0]        trk_sight [CAP];
        int                                  trk_count;
        logic [noat_pkg::DELTA_W-1:0]        window;
        t_assoc_word                         expected_words [$];
        int unsigned                         mismatches;
        int unsigned                         n_merge;
        int unsigned                         n_append;
        int unsigned                         n_drop;
        int unsigned                         n_shift;
        int unsigned                         n_checked;

        function new();
            trk_count  = 0;
            window     = noat_pkg::DELTA_RESET;
            mismatches = 0;
            n_merge    = 0;
            n_append   = 0;
            n_drop     = 0;
            n_shift    = 0;
            n_checked  = 0;
        endfunction

        function void set_window(input logic [noat_pkg::DELTA_W-1:0] v);
            window = v;
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        // predict the result word of one accepted word
        function void note_item(input logic kind,
                                input logic signed [noat_pkg::COORD_W-1:0] px,
                                input logic signed [noat_pkg::COORD_W-1:0] py,
                                input logic [noat_pkg::LABEL_W-1:0] lab);
            t_assoc_word r;
            longint      d;
            longint      ex;
            longint      ey;
            longint      units;
            longint      best_units;
            int          best;
            bit          found;
            r          = '0;
            found      = 0;
            best       = 0;
            best_units = 0;
            d          = longint'(window) << FRAC;
            if (kind == KIND_SHIFT) begin
                for (int i = 0; i < trk_count; i++) begin
                    trk_x[i] = clamp_coord(longint'(trk_x[i]) + longint'(px));
                    trk_y[i] = clamp_coord(longint'(trk_y[i]) + longint'(py));
                end
                n_shift++;
            end else begin
                // nearest candidate inside the window, earliest wins on a tie
                for (int i = 0; i < trk_count; i++) begin
                    ex = longint'(trk_x[i]);
                    ey = longint'(trk_y[i]);
                    if (trk_label[i] == lab && ex - d < px && px < ex + d
                        && ey - d < py && py < ey + d) begin
                        units = ((ex > px ? ex - px : px - ex)
                                 + (ey > py ? ey - py : py - ey)) >>> FRAC;
                        if (!found || units < best_units) begin
                            found      = 1;
                            best       = i;
                            best_units = units;
                        end
                    end
                end
                if (found) begin
                    trk_x[best] = (longint'(trk_x[best]) + longint'(px)) >>> 1;
                    trk_y[best] = (longint'(trk_y[best]) + longint'(py)) >>> 1;
                    if (trk_sight[best] != noat_pkg::SIGHT_MAX)
                        trk_sight[best] = trk_sight[best] + 1'b1;
                    r.matched   = 1'b1;
                    r.object_id = best[noat_pkg::ID_W-1:0];
                    r.sightings = trk_sight[best];
                    r.x         = trk_x[best];
                    r.y         = trk_y[best];
                    n_merge++;
                end else if (trk_count >= CAP) begin
                    r.table_full = 1'b1;
                    n_drop++;
                end else begin
                    trk_x[trk_count]     = px;
                    trk_y[trk_count]     = py;
                    trk_label[trk_count] = lab;
                    trk_sight[trk_count] = '0;
                    r.object_id          = trk_count[noat_pkg::ID_W-1:0];
                    r.x                  = px;
                    r.y                  = py;
                    trk_count++;
                    n_append++;
                end
            end
            expected_words.insert(expected_words.size(), r);
        endfunction

        function void report_mismatch(input string what);
            if (mismatches < 10) $display("mismatch: %s", what);
            mismatches++;
        endfunction

        // compare one accepted result word with the oldest prediction
        function void check_word(input t_assoc_word got);
            t_assoc_word exp;
            if (expected_words.size() == 0) begin
                report_mismatch($sformatf("unexpected word m=%0b f=%0b id=%0d n=%0d x=%0d y=%0d",
                    got.matched, got.table_full, got.object_id, got.sightings, got.x, got.y));
                return;
            end
            exp = expected_words.pop_front();
            n_checked++;
            if (got.matched !== exp.matched || got.table_full !== exp.table_full
                || got.object_id !== exp.object_id || got.sightings !== exp.sightings
                || got.x !== exp.x || got.y !== exp.y)
                report_mismatch($sformatf(
                    "word %0d exp m=%0b f=%0b id=%0d n=%0d x=%0d y=%0d / got m=%0b f=%0b id=%0d n=%0d x=%0d y=%0d",
                    n_checked, exp.matched, exp.table_full, exp.object_id, exp.sightings,
                    exp.x, exp.y, got.matched, got.table_full, got.object_id, got.sightings,
                    got.x, got.y));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // signals
    // ------------------------------------------------------------------------
    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                in_valid = 1'b0;
    logic                                in_kind = 1'b0;
    logic signed [noat_pkg::COORD_W-1:0] in_x = '0;
    logic signed [noat_pkg::COORD_W-1:0] in_y = '0;
    logic [noat_pkg::LABEL_W-1:0]        in_label = '0;
    logic                                out_stall = 1'b0;
    logic                                psel = 1'b0;
    logic                                penable = 1'b0;
    logic                                pwrite = 1'b0;
    logic [noat_pkg::APB_AW-1:0]         paddr = '0;
    logic [noat_pkg::APB_DW-1:0]         pwdata = '0;
    logic [noat_pkg::APB_DW-1:0]         prdata;
    logic                                pready;
    logic                                o_in_stall;
    logic                                o_out_valid;
    t_assoc_word                         out_word;
    bit                                  quiet = 1'b0;
    int                                  stall_left = 0;
    int                                  idle_cycles = 0;
    int unsigned                         n_settings = 0;
    track_scoreboard                     sb;

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    nearest_object_association_table u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (o_in_stall),
        .i_kind           (in_kind),
        .i_pos_x          (in_x),
        .i_pos_y          (in_y),
        .i_class_label    (in_label),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (out_stall),
        .o_matched        (out_word.matched),
        .o_table_full     (out_word.table_full),
        .o_object_id      (out_word.object_id),
        .o_sighting_count (out_word.sightings),
        .o_out_x          (out_word.x),
        .o_out_y          (out_word.y),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    // result word stall in random bursts
    always @(posedge i_clk) begin
        if (quiet) begin
            stall_left <= 0;
            out_stall  <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end else if ($urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(0, 12);
            out_stall  <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    // result word monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && out_stall == 1'b0) sb.check_word(out_word);
    end

    // watchdog on cycles with no word moving
    always @(posedge i_clk) begin
        if ((in_valid && o_in_stall === 1'b0) || (o_out_valid === 1'b1 && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("watchdog: no word moved for %0d cycles, %0d words still due",
                     WATCHDOG, sb.pending());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------

    // present one word, hold it until accepted, then maybe idle
    task automatic send_item(input logic kind,
                             input logic signed [noat_pkg::COORD_W-1:0] x,
                             input logic signed [noat_pkg::COORD_W-1:0] y,
                             input logic [noat_pkg::LABEL_W-1:0] lab);
        in_valid <= 1'b1;
        in_kind  <= kind;
        in_x     <= x;
        in_y     <= y;
        in_label <= lab;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) @(posedge i_clk);
        sb.note_item(kind, x, y, lab);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
    endtask

    // let every outstanding result drain
    task automatic wait_idle();
        in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
        repeat (IDLE_GUARD) @(posedge i_clk);
    endtask

    // apb write then read back the window register
    task automatic set_window(input logic [noat_pkg::DELTA_W-1:0] v);
        logic [noat_pkg::APB_DW-1:0] rd;
        wait_idle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_IDENTITY_DELTA;
        pwdata  <= noat_pkg::APB_DW'(v);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        sb.set_window(v);
        n_settings++;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd[noat_pkg::DELTA_W-1:0] !== v)
            sb.report_mismatch($sformatf("identity_delta read %0h, wrote %0h", rd, v));
    endtask

    // one random word: mostly detections near tracked objects
    task automatic send_random();
        int                                  sel;
        int                                  k;
        longint                              span;
        longint                              ox;
        longint                              oy;
        logic signed [noat_pkg::COORD_W-1:0] x;
        logic signed [noat_pkg::COORD_W-1:0] y;
        logic [noat_pkg::LABEL_W-1:0]        lab;
        sel  = $urandom_range(0, 99);
        span = (longint'(sb.window) << FRAC) + 512;
        if (sel < 10) begin
            // shift, now and then by a full-range offset
            if ($urandom_range(0, 19) == 0) begin
                x = $urandom;
                y = $urandom;
            end else begin
                x = $urandom_range(0, 8192) - 4096;
                y = $urandom_range(0, 8192) - 4096;
            end
            send_item(KIND_SHIFT, x, y, 8'($urandom));
        end else if (sel < 70 && sb.trk_count > 0) begin
            k = $urandom_range(0, sb.trk_count - 1);
            if ($urandom_range(0, 9) == 0) begin
                // right on or just inside the window edge
                ox = (longint'(sb.window) << FRAC) - longint'($urandom_range(0, 1));
                oy = longint'($urandom_range(0, 255));
                if ($urandom_range(0, 1) == 1) ox = -ox;
            end else begin
                ox = longint'($urandom_range(0, 32'(2 * span))) - span;
                oy = longint'($urandom_range(0, 32'(2 * span))) - span;
            end
            x   = clamp_coord(longint'(sb.trk_x[k]) + ox);
            y   = clamp_coord(longint'(sb.trk_y[k]) + oy);
            lab = ($urandom_range(0, 9) == 0) ? 8'($urandom) : sb.trk_label[k];
            send_item(KIND_OBSERVE, x, y, lab);
        end else begin
            // fresh detection
            if ($urandom_range(0, 1) == 0) begin
                x = $urandom_range(0, 131072) - 65536;
                y = $urandom_range(0, 131072) - 65536;
            end else begin
                x = $urandom;
                y = $urandom;
            end
            lab = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 3)) : 8'($urandom);
            send_item(KIND_OBSERVE, x, y, lab);
        end
    endtask

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin
        sb = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero window: every detection appends, duplicates too
        set_window('0);
        send_item(KIND_OBSERVE, noat_pkg::COORD_MIN, noat_pkg::COORD_MAX, 8'd0);
        send_item(KIND_OBSERVE, noat_pkg::COORD_MAX, noat_pkg::COORD_MIN, 8'd255);
        send_item(KIND_OBSERVE, 32'sd0, 32'sd0, 8'd7);
        send_item(KIND_OBSERVE, 32'sd100, 32'sd0, 8'd7);
        send_item(KIND_OBSERVE, 32'sd0, 32'sd0, 8'd7);
        send_item(KIND_SHIFT, 32'sd0, 32'sd0, 8'd0);

        // unit window: tie, negative floor, label miss, window edges
        set_window(16'd1);
        send_item(KIND_OBSERVE, 32'sd50, 32'sd0, 8'd7);
        send_item(KIND_OBSERVE, -32'sd1, -32'sd1, 8'd7);
        send_item(KIND_OBSERVE, 32'sd0, 32'sd0, 8'd8);
        send_item(KIND_OBSERVE, 32'sd256, 32'sd0, 8'd7);
        send_item(KIND_OBSERVE, -32'sd256, 32'sd0, 8'd7);
        send_item(KIND_OBSERVE, 32'sh5555_5555, 32'shAAAA_AAAA, 8'hAA);
        send_item(KIND_SHIFT, noat_pkg::COORD_MAX, noat_pkg::COORD_MAX, 8'd0);
        send_item(KIND_SHIFT, noat_pkg::COORD_MIN, noat_pkg::COORD_MIN, 8'hFF);
        send_item(KIND_OBSERVE, sb.trk_x[0], sb.trk_y[0], sb.trk_label[0]);
        send_item(KIND_SHIFT, -32'sd1, 32'sd1, 8'd0);

        // widest window
        set_window(16'hFFFF);
        send_item(KIND_OBSERVE, clamp_coord(longint'(sb.trk_x[2]) + (64'sd65535 << FRAC) - 1),
                  sb.trk_y[2], 8'd7);
        send_item(KIND_OBSERVE, 32'sd0, 32'sd0, 8'd7);
        send_item(KIND_OBSERVE, noat_pkg::COORD_MIN, noat_pkg::COORD_MIN, 8'd255);

        // random phases with a new window each
        for (int p = 0; p < 6; p++) begin
            case (p)
                0: set_window(16'($urandom_range(2, 8)));
                1: set_window(16'hFFFF);
                2: set_window(16'($urandom_range(100, 5000)));
                3: set_window('0);
                4: set_window(16'($urandom_range(1, 3)));
                default: set_window(16'($urandom_range(0, 65535)));
            endcase
            if (p == 5) quiet = 1'b1;
            repeat ((p == 3) ? 40 : 130) send_random();
        end

        wait_idle();
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("covered %0d words: %0d merges, %0d appends, %0d drops on a full table, %0d shifts",
                 sb.n_checked, sb.n_merge, sb.n_append, sb.n_drop, sb.n_shift);
        $display("window written %0d times, %0d objects tracked, %0d mismatches",
                 n_settings, sb.trk_count, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
